### rtl/core/gnd_pkg.sv
// Shared types, constants and helpers for the gather-nd slice engine.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package gnd_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_RANK_DEF   = 4;
  localparam int unsigned DATA_DEPTH_DEF = 4096;
  localparam int unsigned MAX_SLICE_DEF  = 64;

  // Fixed field widths
  localparam int unsigned NUM_DIM_REGS = 4;
  localparam int unsigned DIM_IW       = 2;   // index into the dimension registers
  localparam int unsigned DIM_W        = 13;  // dimension size register
  localparam int unsigned IDX_W        = 16;  // signed index component
  localparam int unsigned RANK_W       = 3;
  localparam int unsigned ADDR_IN_W    = 12;  // store address field
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned TUPLE_W      = 16;
  localparam int unsigned SLOT_W       = 6;
  localparam int unsigned SLICE_W      = 7;   // slice length, up to 64
  localparam int unsigned CFG_AW       = 3;

  // Saturating product: anything at or above SAT_LIM exceeds any store depth
  localparam int unsigned SAT_W = 18;
  localparam int unsigned SUM_W = 19;
  localparam logic [SAT_W-1:0] SAT_LIM   = 18'h20000;
  localparam logic [DIM_W-1:0] DIM_LIMIT = 13'd4096;

  // Configuration register indexes
  localparam logic [CFG_AW-1:0] REG_DATA_RANK = 3'd0;
  localparam logic [CFG_AW-1:0] REG_TUPLE_LEN = 3'd1;
  localparam logic [CFG_AW-1:0] REG_DIM_0     = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DIM_1     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_DIM_2     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_DIM_3     = 3'd5;

  // Input kind carried on tuser
  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_INDEX = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STRIDE,
    ST_TERM,
    ST_ACC,
    ST_SLICE,
    ST_CHECK,
    ST_READ,
    ST_EMIT,
    ST_ERR
  } gnd_state_e;

  typedef enum logic [1:0] {
    MUL_HOLD,
    MUL_LOAD,
    MUL_STEP
  } mul_op_e;

  typedef struct packed {
    mul_op_e            op;
    logic [SAT_W-1:0]   load_val;
    logic [DIM_W-1:0]   factor;
  } mul_ctrl_t;

  // Dimension size clamped to 1..4096
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (d > DIM_LIMIT) begin
      r = DIM_LIMIT;
    end
    return r;
  endfunction

endpackage

### rtl/core/gnd_mul_sat.sv
// Shared saturating multiply register used for strides, index terms
// and slice lengths. Depends on gnd_pkg.
`timescale 1ns / 1ps

module gnd_mul_sat (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gnd_pkg::mul_ctrl_t         ctrl_i,
  output logic [gnd_pkg::SAT_W-1:0]  prod_o
);
  import gnd_pkg::*;

  localparam int unsigned FULL_W = SAT_W + DIM_W;

  logic [FULL_W-1:0] full;
  logic [SAT_W-1:0]  sat;
  logic [SAT_W-1:0]  prod_d, prod_q;

  assign full = FULL_W'(prod_q) * FULL_W'(ctrl_i.factor);
  assign sat  = (full > FULL_W'(SAT_LIM)) ? SAT_LIM : full[SAT_W-1:0];

  always_comb begin
    case (ctrl_i.op)
      MUL_LOAD: prod_d = ctrl_i.load_val;
      MUL_STEP: prod_d = sat;
      default:  prod_d = prod_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

### rtl/core/gnd_store.sv
// Data word store: one write port, one registered read port.
// Depends on gnd_pkg for the word width.
`timescale 1ns / 1ps

module gnd_store #(
  parameter int unsigned DEPTH = gnd_pkg::DATA_DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [gnd_pkg::WORD_W-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [gnd_pkg::WORD_W-1:0]  rdata_o
);
  import gnd_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/gather_nd_slice_engine_top.sv
// Gather-nd slice engine. A store item is written as it is accepted. An index component
// steps the shared multiplier through its stride product one factor a cycle, then forms
// its index term and adds it to the offset; the last component also forms the slice length,
// then each gathered word is a store read and then the output register, or one error item.
// Reset: sequencer, offset, component count, fault and tuple counter cleared, config
// to data_rank 4, tuple_length 1, sizes 1. The data store is not cleared.
`timescale 1ns / 1ps

module gather_nd_slice_engine_top #(
  parameter int unsigned MAX_RANK   = gnd_pkg::MAX_RANK_DEF,
  parameter int unsigned DATA_DEPTH = gnd_pkg::DATA_DEPTH_DEF,
  parameter int unsigned MAX_SLICE  = gnd_pkg::MAX_SLICE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config write port
  input  logic                          cfg_we_i,
  input  logic [gnd_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  logic [gnd_pkg::DIM_W-1:0]     cfg_wdata_i,
  // input items
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [63:0]                   s_axis_tdata_i,  // store_address[11:0],
                                                         // store_value[43:12],
                                                         // index_value[59:44], pad
  input  logic                          s_axis_tuser_i,  // cmd
  // result items
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [55:0]                   m_axis_tdata_o,  // value[31:0],
                                                         // tuple_number[47:32],
                                                         // slot[53:48], pad
  output logic                          m_axis_tlast_o,  // last
  output logic                          m_axis_tuser_o   // error
);
  import gnd_pkg::*;

  localparam int unsigned AW       = $clog2(DATA_DEPTH);
  localparam int unsigned OW       = $clog2(DATA_DEPTH + 1);
  localparam int unsigned RANK_CAP = (MAX_RANK < NUM_DIM_REGS) ? MAX_RANK : NUM_DIM_REGS;
  localparam logic [SUM_W-1:0]  DEPTH_S     = SUM_W'(DATA_DEPTH);
  localparam logic [SAT_W-1:0]  MAX_SLICE_S = SAT_W'(MAX_SLICE);
  localparam logic [RANK_W-1:0] RANK_CAP_S  = RANK_W'(RANK_CAP);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [RANK_W-1:0] data_rank_q, tuple_length_q;
  logic [DIM_W-1:0]  dim_q [NUM_DIM_REGS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_rank_q    <= RANK_W'(4);
      tuple_length_q <= RANK_W'(1);
      for (int i = 0; i < NUM_DIM_REGS; i++) begin
        dim_q[i] <= DIM_W'(1);
      end
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_DATA_RANK: data_rank_q    <= cfg_wdata_i[RANK_W-1:0];
        REG_TUPLE_LEN: tuple_length_q <= cfg_wdata_i[RANK_W-1:0];
        REG_DIM_0:     dim_q[0]       <= cfg_wdata_i;
        REG_DIM_1:     dim_q[1]       <= cfg_wdata_i;
        REG_DIM_2:     dim_q[2]       <= cfg_wdata_i;
        REG_DIM_3:     dim_q[3]       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  gnd_state_e state_q, state_d;

  logic [1:0]         count_q;      // components seen in the current tuple
  logic [OW-1:0]      offset_q;     // running flat offset
  logic               fault_q;      // range fault seen in the current tuple
  logic [TUPLE_W-1:0] tuple_q;      // completed tuples

  logic [RANK_W-1:0]  rank_q, tl_q, j_q;
  logic [DIM_W-2:0]   idxw_q;       // wrapped index, valid when no fault
  logic               cfault_q;     // this component out of range
  logic               last_comp_q;  // this component closes the tuple
  logic [OW-1:0]      acc_q;        // slice start
  logic               afault_q;
  logic [SLICE_W-1:0] n_q;
  logic [SLOT_W-1:0]  k_q;

  logic               out_valid_q;
  logic [WORD_W-1:0]  out_value_q;
  logic [TUPLE_W-1:0] out_tuple_q;
  logic [SLOT_W-1:0]  out_slot_q;
  logic               out_last_q;
  logic               out_err_q;

  // ---------------------------------------------------------------------------
  // Input decode and effective config
  // ---------------------------------------------------------------------------
  logic                 in_acc, cmd, out_free;
  logic [ADDR_IN_W-1:0] st_addr;
  logic [WORD_W-1:0]    st_value;
  logic [IDX_W-1:0]     idx_raw;
  logic [SUM_W-1:0]     st_addr_ext;
  logic                 st_we;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd      = s_axis_tuser_i;
  assign st_addr  = s_axis_tdata_i[11:0];
  assign st_value = s_axis_tdata_i[43:12];
  assign idx_raw  = s_axis_tdata_i[59:44];
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign st_addr_ext = SUM_W'(st_addr);
  assign st_we       = in_acc && (cmd == CMD_STORE) && (st_addr_ext < DEPTH_S);

  logic [RANK_W-1:0] rank_eff, tl_eff, c_sel, count_ext;
  logic [DIM_W-1:0]  d_cur, dim_j;

  always_comb begin
    if (data_rank_q == '0) begin
      rank_eff = RANK_W'(1);
    end else if (data_rank_q > RANK_CAP_S) begin
      rank_eff = RANK_CAP_S;
    end else begin
      rank_eff = data_rank_q;
    end
    if (tuple_length_q == '0) begin
      tl_eff = RANK_W'(1);
    end else if (tuple_length_q > rank_eff) begin
      tl_eff = rank_eff;
    end else begin
      tl_eff = tuple_length_q;
    end
  end

  assign count_ext = RANK_W'(count_q);
  assign c_sel     = (count_ext >= rank_eff) ? rank_eff - RANK_W'(1) : count_ext;
  assign d_cur     = eff_dim(dim_q[c_sel[DIM_IW-1:0]]);
  assign dim_j     = eff_dim(dim_q[j_q[DIM_IW-1:0]]);

  // Negative index counts from the end of its dimension, once
  localparam int unsigned IW_W = IDX_W + 2;
  logic [IW_W-1:0] idx_ext, d_ext, idx_wrap;
  logic            cfault_new;

  assign idx_ext    = {{2{idx_raw[IDX_W-1]}}, idx_raw};
  assign d_ext      = IW_W'(d_cur);
  assign idx_wrap   = idx_raw[IDX_W-1] ? idx_ext + d_ext : idx_ext;
  assign cfault_new = idx_wrap[IW_W-1] || (idx_wrap >= d_ext);

  // ---------------------------------------------------------------------------
  // Shared multiplier
  // ---------------------------------------------------------------------------
  mul_ctrl_t        mul_ctrl;
  logic [SAT_W-1:0] mul_p;

  gnd_mul_sat u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mul_ctrl),
    .prod_o (mul_p)
  );

  // Offset update after the index term
  logic [SUM_W-1:0] acc_sum, acc_sat, end_sum, rd_sum;
  logic             acc_ovf, slice_err, emit_last, out_load, j_live;

  assign acc_sum   = SUM_W'(offset_q) + SUM_W'(mul_p);
  assign acc_ovf   = acc_sum > DEPTH_S;
  assign acc_sat   = acc_ovf ? DEPTH_S : acc_sum;
  assign end_sum   = SUM_W'(acc_q) + SUM_W'(mul_p);
  assign slice_err = afault_q || (mul_p > MAX_SLICE_S) || (end_sum > DEPTH_S);
  assign rd_sum    = SUM_W'(acc_q) + SUM_W'(k_q);
  assign emit_last = (SLICE_W'(k_q) + SLICE_W'(1)) == n_q;
  assign j_live    = j_q < rank_q;

  // ---------------------------------------------------------------------------
  // Data store
  // ---------------------------------------------------------------------------
  logic              rd_en;
  logic [WORD_W-1:0] rd_data;

  gnd_store #(
    .DEPTH (DATA_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_addr_ext[AW-1:0]),
    .wdata_i (st_value),
    .re_i    (rd_en),
    .raddr_i (rd_sum[AW-1:0]),
    .rdata_o (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc && (cmd == CMD_INDEX)) state_d = ST_STRIDE;
      ST_STRIDE: if (!j_live) state_d = ST_TERM;
      ST_TERM:   state_d = ST_ACC;
      ST_ACC:    state_d = last_comp_q ? ST_SLICE : ST_IDLE;
      ST_SLICE:  if (!j_live) state_d = ST_CHECK;
      ST_CHECK:  state_d = slice_err ? ST_ERR : ST_READ;
      ST_READ:   state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_d = emit_last ? ST_IDLE : ST_READ;
      end
      ST_ERR:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_ctrl.op       = MUL_HOLD;
    mul_ctrl.load_val = SAT_W'(1);
    mul_ctrl.factor   = dim_j;
    rd_en             = 1'b0;
    out_load          = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (cmd == CMD_INDEX)) mul_ctrl.op = MUL_LOAD;
      end
      ST_STRIDE, ST_SLICE: begin
        if (j_live) mul_ctrl.op = MUL_STEP;
      end
      ST_TERM: begin
        // faulty component contributes nothing
        mul_ctrl.op     = MUL_STEP;
        mul_ctrl.factor = cfault_q ? '0 : DIM_W'(idxw_q);
      end
      ST_ACC: begin
        if (last_comp_q) mul_ctrl.op = MUL_LOAD;
      end
      ST_READ:         rd_en    = 1'b1;
      ST_EMIT, ST_ERR: out_load = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      offset_q    <= '0;
      fault_q     <= 1'b0;
      tuple_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ACC) begin
        if (last_comp_q) begin
          count_q  <= '0;
          offset_q <= '0;
          fault_q  <= 1'b0;
        end else begin
          count_q  <= count_q + 2'd1;
          offset_q <= acc_sat[OW-1:0];
          fault_q  <= fault_q | cfault_q | acc_ovf;
        end
      end
      if (out_load && ((state_q == ST_ERR) || emit_last)) begin
        tuple_q <= tuple_q + TUPLE_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Working and output payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          rank_q      <= rank_eff;
          tl_q        <= tl_eff;
          j_q         <= c_sel + RANK_W'(1);
          idxw_q      <= idx_wrap[DIM_W-2:0];
          cfault_q    <= cfault_new;
          last_comp_q <= !((count_ext + RANK_W'(1)) < tl_eff);
        end
      end
      ST_STRIDE, ST_SLICE: begin
        if (j_live) j_q <= j_q + RANK_W'(1);
      end
      ST_ACC: begin
        j_q      <= tl_q;
        acc_q    <= acc_sat[OW-1:0];
        afault_q <= fault_q | cfault_q | acc_ovf;
      end
      ST_CHECK: begin
        n_q <= mul_p[SLICE_W-1:0];
        k_q <= '0;
      end
      ST_EMIT: begin
        if (out_free && !emit_last) k_q <= k_q + SLOT_W'(1);
      end
      default: ;
    endcase

    if (out_load) begin
      out_tuple_q <= tuple_q;
      if (state_q == ST_EMIT) begin
        out_value_q <= rd_data;
        out_slot_q  <= k_q;
        out_last_q  <= emit_last;
        out_err_q   <= 1'b0;
      end else begin
        out_value_q <= '0;
        out_slot_q  <= '0;
        out_last_q  <= 1'b1;
        out_err_q   <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_slot_q, out_tuple_q, out_value_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_err_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_offset_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SUM_W'(offset_q) <= DEPTH_S)
    else $error("running offset beyond store depth");

  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (m_axis_tlast_o && (m_axis_tdata_o[31:0] == '0) && (m_axis_tdata_o[53:48] == '0)))
    else $error("error item not a single zero last item");

  a_tuple_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && ((state_q == ST_ERR) || emit_last)) |=>
      (tuple_q == $past(tuple_q) + TUPLE_W'(1)))
    else $error("tuple counter did not advance at end of slice");

  a_mul_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_p <= SAT_LIM)
    else $error("shared multiplier exceeded saturation limit");

endmodule

### verif/tb_gather_nd_slice_engine_top.sv
// Self-checking testbench for gather_nd_slice_engine_top: stores, index tuples, gathered slices.
// Needs gnd_pkg and the engine RTL; a scoreboard class predicts every result item in order.
`timescale 1ns / 1ps

module tb_gather_nd_slice_engine_top;
  import gnd_pkg::*;

  localparam int unsigned DEPTH       = DATA_DEPTH_DEF;
  localparam int unsigned RANKS       = MAX_RANK_DEF;
  localparam int unsigned SLICE_MAX   = MAX_SLICE_DEF;
  localparam int unsigned SETTLE      = 16;    // wait after the owed results; covers the longest no-result item
  localparam int unsigned STALL_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int unsigned PHASE_ITEMS = 45;

  // one result item as the block presents it
  typedef struct packed {
    logic [WORD_W-1:0]  value;
    logic [TUPLE_W-1:0] tuple_no;
    logic [SLOT_W-1:0]  slot;
    logic               is_last;
    logic               err;
  } gather_result_t;

  // Mirror of the engine: store contents, tuple progress and registers, plus the
  // queue of slice words still owed by the block.
  class gather_scoreboard;
    logic [WORD_W-1:0]  words [DEPTH];
    bit                 written [DEPTH];
    int unsigned        comp_cnt;
    longint unsigned    offset_acc;
    logic [TUPLE_W-1:0] tuple_cnt;
    bit                 fault_q;
    logic [2:0]         rank_reg;
    logic [2:0]         tlen_reg;
    logic [DIM_W-1:0]   dims [NUM_DIM_REGS];
    gather_result_t     owed [$];
    int unsigned        errors;

    function new();
      comp_cnt   = 0;
      offset_acc = 0;
      tuple_cnt  = '0;
      fault_q    = 1'b0;
      rank_reg   = 3'd4;
      tlen_reg   = 3'd1;
      foreach (dims[i]) dims[i] = DIM_W'(1);
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_AW-1:0] a, logic [DIM_W-1:0] v);
      case (a)
        REG_DATA_RANK: rank_reg = v[2:0];
        REG_TUPLE_LEN: tlen_reg = v[2:0];
        REG_DIM_0:     dims[0] = v;
        REG_DIM_1:     dims[1] = v;
        REG_DIM_2:     dims[2] = v;
        REG_DIM_3:     dims[3] = v;
        default: ;
      endcase
    endfunction

    function int unsigned eff_rank();
      int unsigned r;
      r = rank_reg;
      if (r < 1) r = 1;
      if (r > RANKS) r = RANKS;
      return r;
    endfunction

    function int unsigned eff_tlen(int unsigned rank);
      int unsigned t;
      t = tlen_reg;
      if (t < 1) t = 1;
      if (t > rank) t = rank;
      return t;
    endfunction

    function longint unsigned dim_clamped(int unsigned i);
      longint unsigned d;
      d = dims[i & 3];
      if (d < 1) d = 1;
      if (d > 4096) d = 4096;
      return d;
    endfunction

    // product of the sizes of dimensions first .. rank-1
    function longint unsigned span(int unsigned first, int unsigned rank);
      longint unsigned p;
      p = 1;
      for (int unsigned i = first; i < rank; i++) p = p * dim_clamped(i);
      return p;
    endfunction

    function int unsigned cur_comp();
      int unsigned c;
      c = comp_cnt & 3;
      if (c >= eff_rank()) c = eff_rank() - 1;
      return c;
    endfunction

    function longint unsigned cur_dim();
      return dim_clamped(cur_comp());
    endfunction

    // next index component finishes the tuple
    function bit completes();
      return (comp_cnt + 1) >= eff_tlen(eff_rank());
    endfunction

    // One index component. Returns 1 when the tuple finishes; len 0 then means an
    // error item. With commit clear the state is left untouched (look-ahead).
    function bit evaluate(input logic signed [IDX_W-1:0] idx, input bit commit,
                          output int unsigned base, output int unsigned len);
      int unsigned     rank, tl, c;
      longint          sidx;
      longint unsigned d, term, acc, slice;
      bit              flt;
      rank = eff_rank();
      tl   = eff_tlen(rank);
      c    = cur_comp();
      d    = dim_clamped(c);
      base = 0;
      len  = 0;
      sidx = idx;
      if (sidx < 0) sidx = sidx + longint'(d);   // counts from the end, once
      flt = fault_q;
      if (sidx < 0 || longint'(d) <= sidx) begin
        flt  = 1'b1;
        term = 0;
      end else begin
        term = longint'(sidx) * span(c + 1, rank);
      end
      acc = offset_acc + term;
      if (acc > DEPTH) begin
        flt = 1'b1;
        acc = DEPTH;
      end
      if (comp_cnt + 1 < tl) begin
        if (commit) begin
          comp_cnt   = (comp_cnt + 1) & 3;
          offset_acc = acc;
          fault_q    = flt;
        end
        return 1'b0;
      end
      if (commit) begin
        comp_cnt   = 0;
        offset_acc = 0;
        fault_q    = 1'b0;
      end
      slice = span(tl, rank);
      if (!flt && slice <= SLICE_MAX && acc + slice <= DEPTH) begin
        base = 32'(acc);
        len  = 32'(slice);
      end
      return 1'b1;
    endfunction

    function void note_input(logic cmd, logic [ADDR_IN_W-1:0] addr, logic [WORD_W-1:0] val,
                             logic signed [IDX_W-1:0] idx);
      int unsigned    base, len;
      gather_result_t r;
      if (cmd == CMD_STORE) begin
        words[addr]   = val;
        written[addr] = 1'b1;
        return;
      end
      if (!evaluate(idx, 1'b1, base, len)) return;
      r.tuple_no = tuple_cnt;
      if (len == 0) begin
        r.value   = '0;
        r.slot    = '0;
        r.is_last = 1'b1;
        r.err     = 1'b1;
        owed.push_back(r);
      end else begin
        for (int unsigned k = 0; k < len; k++) begin
          r.value   = words[base + k];
          r.slot    = SLOT_W'(k);
          r.is_last = (k + 1 == len);
          r.err     = 1'b0;
          owed.push_back(r);
        end
      end
      tuple_cnt = tuple_cnt + 1'b1;
    endfunction

    function void compare_field(string name, logic [WORD_W-1:0] exp, logic [WORD_W-1:0] act);
      if (act !== exp) begin
        $display("%0t mismatch on %s: expected %h, actual %h", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(gather_result_t got);
      gather_result_t exp;
      if (owed.size() == 0) begin
        $display("%0t unexpected result item: value %h tuple %0d slot %0d last %b err %b",
                 $time, got.value, got.tuple_no, got.slot, got.is_last, got.err);
        errors++;
        return;
      end
      exp = owed.pop_front();
      compare_field("value", exp.value, got.value);
      compare_field("tuple_number", WORD_W'(exp.tuple_no), WORD_W'(got.tuple_no));
      compare_field("slot", WORD_W'(exp.slot), WORD_W'(got.slot));
      compare_field("last", WORD_W'(exp.is_last), WORD_W'(got.is_last));
      compare_field("error", WORD_W'(exp.err), WORD_W'(got.err));
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_AW-1:0]    cfg_addr_i;
  logic [DIM_W-1:0]     cfg_wdata_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [63:0]          s_axis_tdata_i;   // store_address, store_value, index_value, pad
  logic                 s_axis_tuser_i;   // cmd
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [55:0]          m_axis_tdata_o;   // value, tuple_number, slot, pad
  logic                 m_axis_tlast_o;   // last
  logic                 m_axis_tuser_o;   // error

  gather_scoreboard     sb;
  int unsigned          send_idle_pct;
  int unsigned          recv_stall_pct;
  int unsigned          items_sent;
  int unsigned          quiet_cycles;

  gather_nd_slice_engine_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #2 clk_i = ~clk_i;

  // Result side: check what moved at this edge, then pick next cycle's ready.
  always @(posedge clk_i) begin
    gather_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.value    = m_axis_tdata_o[31:0];
      got.tuple_no = m_axis_tdata_o[47:32];
      got.slot     = m_axis_tdata_o[53:48];
      got.is_last  = m_axis_tlast_o;
      got.err      = m_axis_tuser_o;
      sb.check_result(got);
    end
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: a run that stops moving items is a failure.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  // One input item; tvalid stays up after acceptance so back-to-back items need
  // no second assignment in the same step.
  task automatic send_item(input logic cmd, input logic [ADDR_IN_W-1:0] addr,
                           input logic [WORD_W-1:0] val, input logic [IDX_W-1:0] idx);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {4'b0, idx, val, addr};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(cmd, addr, val, idx);
    items_sent++;
  endtask

  // Index component; a tuple-ending one first gets every word of its slice
  // stored, so the block never reads a word that was never written.
  task automatic send_component(input logic signed [IDX_W-1:0] idx);
    int unsigned base, len;
    if (sb.completes()) begin
      void'(sb.evaluate(idx, 1'b0, base, len));
      for (int unsigned k = 0; k < len; k++) begin
        if (!sb.written[base + k]) send_item(CMD_STORE, ADDR_IN_W'(base + k), $urandom(),
                                             IDX_W'($urandom()));
      end
    end
    send_item(CMD_INDEX, ADDR_IN_W'($urandom()), $urandom(), idx);
  endtask

  // Hold the sender until every owed result is out, then let the engine settle.
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic configure(input int unsigned rank, input int unsigned tlen,
                           input int unsigned d0, input int unsigned d1,
                           input int unsigned d2, input int unsigned d3);
    logic [CFG_AW-1:0] regs [6];
    int unsigned       vals [6];
    regs = '{REG_DATA_RANK, REG_TUPLE_LEN, REG_DIM_0, REG_DIM_1, REG_DIM_2, REG_DIM_3};
    vals = '{rank, tlen, d0, d1, d2, d3};
    drain();
    for (int i = 0; i < 6; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= regs[i];
      cfg_wdata_i <= DIM_W'(vals[i]);
      @(posedge clk_i);
      sb.write_reg(regs[i], DIM_W'(vals[i]));
    end
    cfg_we_i <= 1'b0;
  endtask

  // Mostly small index ranges and small slices; now and then a huge dimension,
  // an oversize slice or a register value the block has to saturate.
  task automatic random_config(input bit max_slice);
    int unsigned rank, tlen;
    int unsigned dim [4];
    rank = $urandom_range(1, RANKS);
    tlen = $urandom_range(1, rank);
    for (int i = 0; i < 4; i++) begin
      if (i < tlen) begin
        dim[i] = ($urandom_range(7) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 16);
      end else begin
        dim[i] = ($urandom_range(7) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 4);
      end
    end
    if (max_slice) begin
      // full 64-word slices, slot reaches its top value
      rank   = 2;
      tlen   = 1;
      dim[0] = $urandom_range(1, 64);
      dim[1] = SLICE_MAX;
    end else if ($urandom_range(9) == 0) begin
      case ($urandom_range(2))
        0:       rank = ($urandom_range(1) == 0) ? 0 : $urandom_range(5, 7);
        1:       tlen = ($urandom_range(1) == 0) ? 0 : $urandom_range(rank + 1, 7);
        default: dim[$urandom_range(3)] = ($urandom_range(1) == 0) ? 0 :
                                          $urandom_range(4097, 8191);
      endcase
    end
    configure(rank, tlen, dim[0], dim[1], dim[2], dim[3]);
  endtask

  // Whole tuple from the current state; most components in range, some noise.
  task automatic random_tuple();
    bit                      done;
    int                      v;
    logic signed [IDX_W-1:0] idx;
    done = 1'b0;
    while (!done) begin
      done = sb.completes();
      if ($urandom_range(99) < 85) begin
        v   = int'($urandom_range(2 * int'(sb.cur_dim()) - 1)) - int'(sb.cur_dim());
        idx = v[IDX_W-1:0];
      end else begin
        idx = IDX_W'($urandom());
      end
      send_component(idx);
    end
  endtask

  initial begin
    sb              = new();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    items_sent      = 0;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_addr_i      <= '0;
    cfg_wdata_i     <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= CMD_STORE;
    m_axis_tready_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed part ----
    // two-word slices over a 2048-row table; extremes of the store fields
    configure(2, 1, 2048, 2, 1, 1);
    send_item(CMD_STORE, 12'hFFF, 32'hFFFF_FFFF, 16'h0000);
    send_item(CMD_STORE, 12'h000, 32'h0000_0000, 16'hFFFF);
    send_component(16'sd2047);          // slice ends on the top word of the store
    send_component(-16'sd2048);         // negative index wraps to row 0
    send_component(16'sd2048);          // component one past its size
    send_component(-16'sd2049);         // still negative after the wrap
    send_component(16'sh7FFF);
    send_component(16'sh8000);

    // offset plus slice length beyond the store, and the last slice that fits
    configure(2, 1, 4096, 4, 1, 1);
    send_component(16'sd1024);
    send_component(16'sd1023);

    // slice longer than the maximum
    configure(2, 1, 1, 65, 1, 1);
    send_component(16'sd0);

    // saturating registers: rank 7 -> 4, length 0 -> 1, size 8191 -> 4096, 0 -> 1
    configure(7, 0, 8191, 0, 1, 1);
    send_component(16'sd4095);
    send_component(-16'sd4096);
    // rank 0 -> 1, tuple length above the rank
    configure(0, 3, 5, 1, 1, 1);
    send_component(16'sd4);
    send_component(16'sd5);

    // accumulated offset overflow in the first component, error after the second
    configure(3, 2, 4096, 4096, 1, 1);
    send_component(16'sd5);
    send_component(16'sd0);

    // full three-component tuple (length 7 clamps to the rank)
    configure(3, 7, 4, 4, 4, 1);
    send_component(16'sd1);
    send_component(-16'sd1);
    send_component(16'sd2);
    // registers changed while a tuple is half collected
    send_component(16'sd1);
    configure(3, 2, 4, 4, 4, 1);
    send_component(16'sd2);

    // ---- random part, one phase per idling pattern ----
    for (int p = 0; p < 4; p++) begin
      int unsigned start;
      int unsigned r;
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      random_config(p == 0);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        r = $urandom_range(99);
        if (r < 12) begin
          send_item(CMD_STORE, ADDR_IN_W'($urandom()), $urandom(), IDX_W'($urandom()));
        end else if (r < 18) begin
          random_config(1'b0);
        end else begin
          random_tuple();
        end
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
